/* rtl/core/stgd_pkg.sv */
// ----------------------------------------------------------------------------
// stgd_pkg
// Types, constants and elaboration-time table builders for the sine tone
// generator with decay.
// ----------------------------------------------------------------------------
package stgd_pkg;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_KEY  = 1'b1
	} op_t;

	localparam int OP_W      = 1;
	localparam int NOTE_W    = 4;
	localparam int SAMPLE_W  = 16;
	localparam int PEAK_W    = 16;
	localparam int DECAY_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int MAG_W     = 15;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PEAK_LEVEL = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_DECAY_STEP = cfg_idx_t'(1);

	localparam logic [PEAK_W-1:0]  PEAK_RESET  = 16'd65534;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd3;

	localparam int NOTE_COUNT = 13;
	localparam logic [63:0] SAMPLE_RATE_E4 = 64'd441000000;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

	// note frequencies C4..C5 in units of 1e-4 Hz
	localparam logic [31:0] NOTE_FREQ_E4 [NOTE_COUNT] = '{
		32'd2616256, 32'd2771826, 32'd2936648, 32'd3111270, 32'd3296276,
		32'd3492282, 32'd3699944, 32'd3919954, 32'd4153047, 32'd4400000,
		32'd4661638, 32'd4938833, 32'd5232511
	};

	// one Taylor term divided by (2n)(2n+1)
	function automatic logic [63:0] taylor_div(input int n, input logic [63:0] t);
		logic [63:0] r;
		case (n)
			1:       r = t / 64'd6;
			2:       r = t / 64'd20;
			3:       r = t / 64'd42;
			4:       r = t / 64'd72;
			5:       r = t / 64'd110;
			6:       r = t / 64'd156;
			7:       r = t / 64'd210;
			default: r = t / 64'd272;
		endcase
		return r;
	endfunction

	// round(32767 * sin(k/quarter * pi/2)), Q30 series, used with constant args only
	function automatic logic [MAG_W-1:0] quarter_sine(input int k, input int tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] val;
		x    = (64'(k) * HALF_PI_Q30) >> (tbits - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= 8; n++) begin
			term = taylor_div(n, (term * x2) >> 30);
			if (n % 2 == 1) begin
				sum = (sum > term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		val = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		return val[MAG_W-1:0];
	endfunction

	// round(f * 2^pbits / 44100 Hz), halves up, by restoring long division
	function automatic logic [63:0] increment_for(input logic [31:0] f, input int pbits);
		logic [63:0] q;
		logic [63:0] r;
		q = 64'd0;
		r = 64'(f);
		for (int b = 0; b <= pbits; b++) begin
			r = r << 1;
			q = q << 1;
			if (r >= SAMPLE_RATE_E4) begin
				r = r - SAMPLE_RATE_E4;
				q = q | 64'd1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

endpackage

/* rtl/core/stgd_ifs.sv */
// ----------------------------------------------------------------------------
// stgd_ifs
// Valid/ready channels of the tone generator: command, PCM result, config.
// ----------------------------------------------------------------------------
interface stgd_cmd_if;
	logic       valid;
	logic       ready;
	logic [0:0] op;
	logic [3:0] note;

	modport source (output valid, output op, output note, input ready);
	modport sink   (input valid, input op, input note, output ready);
endinterface

interface stgd_pcm_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface stgd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/stgd_sine_rom.sv */
// ----------------------------------------------------------------------------
// stgd_sine_rom
// Quarter-wave Q15 sine table with quadrant folding and a registered output
// (magnitude and sign kept apart).
// ----------------------------------------------------------------------------
module stgd_sine_rom #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [SINE_TABLE_BITS-1:0] addr,
	output logic [stgd_pkg::MAG_W-1:0] mag,
	output logic                       neg
);
	import stgd_pkg::*;

	localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
	localparam int QA_W    = SINE_TABLE_BITS - 1;

	logic [MAG_W-1:0] qtab [QUARTER+1];
	logic [1:0]       quad;
	logic [QA_W-1:0]  k;
	logic [QA_W-1:0]  qaddr;

	for (genvar i = 0; i <= QUARTER; i++) begin : g_qtab
		assign qtab[i] = quarter_sine(i, SINE_TABLE_BITS);
	end

	assign quad = addr[SINE_TABLE_BITS-1 -: 2];
	assign k    = {1'b0, addr[SINE_TABLE_BITS-3:0]};
	// odd quadrants run the quarter wave backwards
	assign qaddr = quad[0] ? (QA_W'(QUARTER) - k) : k;

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= qtab[qaddr];
			neg <= quad[1];
		end
	end

endmodule

/* rtl/core/sine_tone_generator_with_decay_unit.sv */
// ----------------------------------------------------------------------------
// sine_tone_generator_with_decay_unit
// DDS sine oscillator with linear envelope decay, stereo PCM16 out.
// ----------------------------------------------------------------------------
// Pipeline: a tick item's sample passes the index register, the table read
//   and the envelope multiply into the output register, in that order.
// Throughput: one item per cycle if pcm is not stalled; keys give no sample.
// Reset: phase and increment zero (silence), envelope and peak 65534,
//   decay step 3; the config channel is always ready.
module sine_tone_generator_with_decay_unit #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int PHASE_BITS      = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	stgd_cmd_if.sink   cmd,
	stgd_pcm_if.source pcm,
	stgd_cfg_if.sink   cfg
);
	import stgd_pkg::*;

	logic [PHASE_BITS-1:0] incr_tab [NOTE_COUNT];

	for (genvar n = 0; n < NOTE_COUNT; n++) begin : g_incr
		assign incr_tab[n] = PHASE_BITS'(increment_for(NOTE_FREQ_E4[n], PHASE_BITS));
	end

	logic [PEAK_W-1:0]     peak_q;
	logic [DECAY_W-1:0]    decay_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] incr_q;
	logic [PEAK_W-1:0]     env_q;
	logic [PHASE_BITS-1:0] phase_next;
	logic [PEAK_W-1:0]     env_next;

	logic                       s1_v;
	logic [SINE_TABLE_BITS-1:0] idx_s1;
	logic [PEAK_W-1:0]          env_s1;
	logic                       s2_v;
	logic [MAG_W-1:0]           mag_s2;
	logic                       neg_s2;
	logic [PEAK_W-1:0]          env_s2;
	logic                       out_v_q;
	logic [SAMPLE_W-1:0]        sample_q;

	logic                   out_en;
	logic                   s2_en;
	logic                   s1_en;
	logic                   in_acc;
	logic                   is_tick;
	logic                   key_ok;
	logic [MAG_W+PEAK_W-1:0] prod;
	logic [SAMPLE_W-1:0]    scaled;

	assign out_en  = !out_v_q || pcm.ready;
	assign s2_en   = !s2_v || out_en;
	assign s1_en   = !s1_v || s2_en;
	assign in_acc  = cmd.valid && cmd.ready;
	assign is_tick = (op_t'(cmd.op) == OP_TICK);
	assign key_ok  = (op_t'(cmd.op) == OP_KEY) && (cmd.note < NOTE_W'(NOTE_COUNT));

	assign cmd.ready = s1_en;
	assign cfg.ready = 1'b1;

	assign phase_next = phase_q + incr_q;
	assign env_next   = (env_q > PEAK_W'(decay_q)) ? (env_q - PEAK_W'(decay_q)) : '0;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= PEAK_RESET;
			decay_q <= DECAY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_PEAK_LEVEL: peak_q  <= cfg.data[PEAK_W-1:0];
				CFG_DECAY_STEP: decay_q <= cfg.data[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	// oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			incr_q  <= '0;
			env_q   <= PEAK_RESET;
		end else if (in_acc) begin
			if (is_tick) begin
				phase_q <= phase_next;
				env_q   <= env_next;
			end else if (key_ok) begin
				incr_q <= incr_tab[cmd.note];
				env_q  <= peak_q;
			end
		end
	end

	// stage 1: table index and envelope from before this tick's update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_en) begin
			s1_v <= in_acc && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && in_acc && is_tick) begin
			idx_s1 <= phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
			env_s1 <= env_q;
		end
	end

	// stage 2: table read
	stgd_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.en   (s2_en && s1_v),
		.addr (idx_s1),
		.mag  (mag_s2),
		.neg  (neg_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_en) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && s1_v) begin
			env_s2 <= env_s1;
		end
	end

	// stage 3: scale magnitude, truncating toward zero, then apply sign
	assign prod   = (MAG_W+PEAK_W)'(mag_s2) * (MAG_W+PEAK_W)'(env_s2);
	assign scaled = SAMPLE_W'(prod[MAG_W+PEAK_W-1:PEAK_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && s2_v) begin
			sample_q <= neg_s2 ? (SAMPLE_W'(0) - scaled) : scaled;
		end
	end

	assign pcm.valid        = out_v_q;
	assign pcm.left_sample  = sample_q;
	assign pcm.right_sample = sample_q;

	// checks
	a_key_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !is_tick |=> !s1_v)
		else $error("key press entered the sample pipeline");

	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_tick |=> s1_v)
		else $error("tick lost before stage 1");

	a_key_loads_env: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && key_ok |=> env_q == $past(peak_q))
		else $error("envelope not restarted at peak on key press");

	a_phase_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_tick |=> phase_q == $past(phase_next))
		else $error("phase did not advance by the increment");

	a_env_falls: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_tick |=> env_q <= $past(env_q))
		else $error("envelope rose on a tick");

endmodule
